/* sv/cmg_pkg.sv */
// Shared types, constants and hue tables for the colormap entry generator.
`timescale 1ns / 1ps

package cmg_pkg;

    // Map selection codes
    typedef enum logic [1:0] {
        MODE_RED_BLUE = 2'd0,
        MODE_RAINBOW  = 2'd1,
        MODE_GRAY     = 2'd2,
        MODE_INV_GRAY = 2'd3
    } t_map_mode;

    // Configuration register indexes
    localparam logic REG_MAP_MODE  = 1'b0;
    localparam logic REG_MAX_INDEX = 1'b1;

    // Quotient / root bits resolved per pipeline stage
    localparam int DIV_STEP = 2;

    // Byte conversion: floor(x * 255.499), done as x * 255499 / 1000
    localparam int TO_BYTE_MUL = 255499;
    localparam int BYTE_DIV    = 1000;
    // 1048 / 2^20 slightly under 1/1000, fixed by one correction step
    localparam int RECIP_MUL   = 1048;
    localparam int RECIP_SHIFT = 20;

    // Perceptual hue table, knots and hues in units of 1/10000
    localparam int HUE_POINTS = 65;
    typedef int unsigned t_knot_arr [HUE_POINTS];

    localparam t_knot_arr KNOT_X = '{
        0, 156, 313, 469, 625, 781, 938, 1094, 1250, 1406,
        1563, 1719, 1875, 2031, 2188, 2344, 2500, 2656, 2813, 2969,
        3125, 3281, 3438, 3594, 3750, 3906, 4063, 4219, 4375, 4531,
        4688, 4844, 5000, 5156, 5313, 5469, 5625, 5781, 5938, 6094,
        6250, 6406, 6563, 6719, 6875, 7031, 7188, 7344, 7500, 7656,
        7813, 7969, 8125, 8281, 8438, 8594, 8750, 8906, 9063, 9219,
        9375, 9531, 9688, 9844, 10000
    };

    localparam t_knot_arr KNOT_T = '{
        0, 52, 105, 160, 218, 277, 339, 404, 471, 542,
        616, 693, 775, 862, 954, 1052, 1157, 1269, 1390, 1519,
        1660, 1824, 1974, 2115, 2248, 2374, 2495, 2609, 2719, 2824,
        2926, 3023, 3118, 3210, 3300, 3456, 3600, 3761, 3943, 4153,
        4399, 4688, 5048, 5211, 5359, 5494, 5617, 5729, 5832, 5925,
        6010, 6088, 6160, 6225, 6285, 6340, 6390, 6436, 6478, 6516,
        6552, 6584, 6614, 6642, 6667
    };

    // Per-segment hue base times segment width
    function automatic t_knot_arr f_knot_base();
        t_knot_arr v;
        for (int j = 0; j < HUE_POINTS; j++) begin
            if (j < HUE_POINTS - 1) begin
                v[j] = KNOT_T[j] * (KNOT_X[j + 1] - KNOT_X[j]);
            end else begin
                v[j] = 0;
            end
        end
        return v;
    endfunction

    // Per-segment divisor: 10000 times segment width
    function automatic t_knot_arr f_knot_den();
        t_knot_arr v;
        for (int j = 0; j < HUE_POINTS; j++) begin
            if (j < HUE_POINTS - 1) begin
                v[j] = 10000 * (KNOT_X[j + 1] - KNOT_X[j]);
            end else begin
                v[j] = 1;
            end
        end
        return v;
    endfunction

    localparam t_knot_arr KNOT_BASE = f_knot_base();
    localparam t_knot_arr KNOT_DEN  = f_knot_den();

endpackage

/* sv/cmg_if.sv */
// Handshake channel interfaces: index input, color output, configuration writes.
`timescale 1ns / 1ps

interface cmg_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] entry_index;

    modport source (output valid, output entry_index, input ready);
    modport sink   (input valid, input entry_index, output ready);
endinterface

interface cmg_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_out;

    modport source (output valid, output red, output green, output blue,
                    output entry_out, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input entry_out, output ready);
endinterface

interface cmg_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/cmg_div.sv */
// Pipelined restoring divider, a few quotient bits per stage.
`timescale 1ns / 1ps

module cmg_div #(
    parameter int N    = 24,
    parameter int D    = 8,
    parameter int Q    = 17,
    parameter int STEP = 2
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [N-1:0] i_num,
    input  logic [D-1:0] i_den,
    output logic [Q-1:0] o_quo
);

    localparam int S  = (Q + STEP - 1) / STEP;
    localparam int QP = S * STEP;

    // Caller guarantees i_num < i_den * 2^Q, so the top part is already below i_den
    logic [D-1:0]  r_rem [S];
    logic [QP-1:0] r_low [S];
    logic [QP-1:0] r_quo [S];
    logic [D-1:0]  r_den [S];

    for (genvar s = 0; s < S; s++) begin : g_stage
        logic [D-1:0]  w_rem_in;
        logic [QP-1:0] w_low_in;
        logic [QP-1:0] w_quo_in;
        logic [D-1:0]  w_den_in;
        logic [D-1:0]  n_rem;
        logic [QP-1:0] n_low;
        logic [QP-1:0] n_quo;

        if (s == 0) begin : g_first
            assign w_rem_in = D'(i_num >> QP);
            assign w_low_in = i_num[QP-1:0];
            assign w_quo_in = '0;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_low_in = r_low[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_den_in = r_den[s-1];
        end

        // Shift in one dividend bit, subtract when it fits
        always_comb begin
            logic [D:0] v_trial;
            n_rem = w_rem_in;
            n_low = w_low_in;
            n_quo = w_quo_in;
            for (int k = 0; k < STEP; k++) begin
                v_trial = {n_rem, n_low[QP-1]};
                n_low   = n_low << 1;
                if (v_trial >= {1'b0, w_den_in}) begin
                    n_rem = D'(v_trial - {1'b0, w_den_in});
                    n_quo = {n_quo[QP-2:0], 1'b1};
                end else begin
                    n_rem = v_trial[D-1:0];
                    n_quo = {n_quo[QP-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_low[s] <= n_low;
                r_quo[s] <= n_quo;
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[S-1][Q-1:0];

endmodule

/* sv/cmg_sqrt.sv */
// Pipelined square root of a Q1.W value, returned in Q1.W (floor of sqrt(x * 2^W)).
`timescale 1ns / 1ps

module cmg_sqrt #(
    parameter int W    = 16,
    parameter int STEP = 2
) (
    input  logic       i_clk,
    input  logic       i_en,
    input  logic [W:0] i_x,
    output logic [W:0] o_root
);

    localparam int RB = W + 1;
    localparam int S  = (RB + STEP - 1) / STEP;
    localparam int RP = S * STEP;
    localparam int RW = RP + 2;
    localparam int AW = 2 * RP;

    logic [RW-1:0] r_rem  [S];
    logic [RP-1:0] r_root [S];
    logic [AW-1:0] r_rad  [S];

    for (genvar s = 0; s < S; s++) begin : g_stage
        logic [RW-1:0] w_rem_in;
        logic [RP-1:0] w_root_in;
        logic [AW-1:0] w_rad_in;
        logic [RW-1:0] n_rem;
        logic [RP-1:0] n_root;
        logic [AW-1:0] n_rad;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = AW'({i_x, {W{1'b0}}});
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
            assign w_rad_in  = r_rad[s-1];
        end

        // One root bit per step: bring down two radicand bits, try root*4+1
        always_comb begin
            logic [RW+1:0] v_acc;
            logic [RW+1:0] v_trial;
            n_rem  = w_rem_in;
            n_root = w_root_in;
            n_rad  = w_rad_in;
            for (int k = 0; k < STEP; k++) begin
                v_acc   = {n_rem, n_rad[AW-1:AW-2]};
                v_trial = (RW+2)'({n_root, 2'b01});
                n_rad   = n_rad << 2;
                if (v_acc >= v_trial) begin
                    n_rem  = RW'(v_acc - v_trial);
                    n_root = {n_root[RP-2:0], 1'b1};
                end else begin
                    n_rem  = RW'(v_acc);
                    n_root = {n_root[RP-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
                r_rad[s]  <= n_rad;
            end
        end
    end

    assign o_root = r_root[S-1][RB-1:0];

endmodule

/* sv/colormap_entry_generator.sv */
// Top level: pipelined colormap entry generator (index in, red/green/blue out).
`timescale 1ns / 1ps

// Usage
//   i_in  : one beat carries entry_index; it is saturated to max_index.
//   o_out : one beat per input beat with red, green, blue and the saturated
//           index (entry_out), in input order.
//   i_cfg : register writes, index 0 map_mode, index 1 max_index (values above
//           MAX_ENTRIES-1 are stored as MAX_ENTRIES-1). Always ready; write
//           only while no beats are in flight.
// Throughput: one beat per cycle while the output is not stalled. The depth of
//   the pipeline from input beat to output beat is set by the dividers (ratio,
//   hue segment interpolation, red-blue rescale) and the square root, each
//   resolving two bits per stage.
// Reset: all valid bits clear, map_mode returns to rainbow and max_index to
//   253. No clearing pass.
// Stall: the whole pipeline holds while the output beat waits; i_in.ready
//   drops in the same cycle, nothing is lost or repeated.
module colormap_entry_generator #(
    parameter int MAX_ENTRIES = 254,
    parameter int FRAC_BITS   = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    cmg_in_if.sink    i_in,
    cmg_cfg_if.sink   i_cfg,
    cmg_out_if.source o_out
);

    import cmg_pkg::*;

    localparam int QW    = FRAC_BITS + 1;
    localparam int L1    = (QW + DIV_STEP - 1) / DIV_STEP;
    localparam int L2    = (FRAC_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int L3    = (QW + DIV_STEP - 1) / DIV_STEP;
    localparam int L4    = (QW + DIV_STEP - 1) / DIV_STEP;
    localparam int T_DLY = 4 + L2;
    localparam int LAT   = 1 + L1 + 4 + L2 + 1 + L3 + L4 + 3;
    localparam int HW    = FRAC_BITS + 15;
    localparam int DHW   = FRAC_BITS + 8;
    localparam int PW    = FRAC_BITS + 17;
    localparam int BW    = 21;
    localparam int NW2   = FRAC_BITS + 22;
    localparam int CW    = QW + 18;
    localparam int YW    = 18;
    localparam int EW    = 29;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

    // Configuration registers
    t_map_mode  r_map_mode;
    logic [7:0] r_max_index;

    // Valid and index shift lines
    logic       r_vld [LAT];
    logic [7:0] r_idx [LAT];
    logic       w_en;

    // Stage signals
    logic [7:0]     w_sat_idx;
    logic [7:0]     w_div1_den;
    logic [QW-1:0]  w_t;
    logic [QW-1:0]  r_t_dly [T_DLY];
    logic [QW-1:0]  w_b_h;
    logic [HW-1:0]  r_b_hh;
    logic [6:0]     r_b_j0;
    logic [5:0]     w_c_j0c;
    logic [6:0]     w_c_jn;
    logic [5:0]     w_c_j;
    logic [HW-1:0]  r_c_hh;
    logic [5:0]     r_c_j;
    logic [DHW-1:0] w_d_dh;
    logic [8:0]     w_d_dt;
    logic [BW-1:0]  r_d_base;
    logic [PW-1:0]  r_d_prod;
    logic [BW-1:0]  r_d_den;
    logic [NW2-1:0] r_e_num;
    logic [BW-1:0]  r_e_den;
    logic [FRAC_BITS-1:0] w_hue;
    logic [FRAC_BITS+2:0] w_f_h6;
    logic [2:0]     w_f_sector;
    logic [QW-1:0]  w_f_frac;
    logic [QW-1:0]  w_f_t;
    logic [QW-1:0]  w_f_ti;
    logic [QW-1:0]  w_f_x [3];
    logic [QW-1:0]  r_f_x [3];
    logic [QW-1:0]  w_sq [3];
    logic [QW-1:0]  r_sq_dly [L4][3];
    logic [QW-1:0]  w_max;
    logic [QW-1:0]  w_dr;
    logic [QW-1:0]  w_db;
    logic [QW-1:0]  w_h_c [3];
    logic [CW-1:0]  r_h_prod [3];
    logic [YW-1:0]  w_i_y [3];
    logic [YW-1:0]  r_i_y [3];
    logic [EW-1:0]  r_i_est [3];
    logic [7:0]     r_j_byte [3];

    // Pipeline advances unless the output beat is stuck
    assign w_en        = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready  = w_en;
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_mode  <= MODE_RAINBOW;
            r_max_index <= 8'd253;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MAP_MODE: begin
                    r_map_mode <= t_map_mode'(i_cfg.data[1:0]);
                end
                REG_MAX_INDEX: begin
                    if ({1'b0, i_cfg.data} > 9'(MAX_ENTRIES - 1)) begin
                        r_max_index <= 8'(MAX_ENTRIES - 1);
                    end else begin
                        r_max_index <= i_cfg.data;
                    end
                end
            endcase
        end
    end

    // Saturate the incoming index
    assign w_sat_idx = (i_in.entry_index > r_max_index) ? r_max_index : i_in.entry_index;

    // Valid bits travel with the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_idx[0] <= w_sat_idx;
            for (int k = 1; k < LAT; k++) begin
                r_idx[k] <= r_idx[k-1];
            end
        end
    end

    // Ratio t = index * 2^F / max_index; a zero max gives t = 0 (index is 0 too)
    assign w_div1_den = (r_max_index == 8'd0) ? 8'd1 : r_max_index;

    cmg_div #(
        .N    (FRAC_BITS + 8),
        .D    (8),
        .Q    (QW),
        .STEP (DIV_STEP)
    ) u_div_ratio (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r_idx[0], {FRAC_BITS{1'b0}}}),
        .i_den (w_div1_den),
        .o_quo (w_t)
    );

    // Hold t until the hexcone stage
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_dly[0] <= w_t;
            for (int k = 1; k < T_DLY; k++) begin
                r_t_dly[k] <= r_t_dly[k-1];
            end
        end
    end

    // Hue 1-t scaled by 10000, coarse segment from the top bits
    assign w_b_h = ONE_Q - w_t;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_hh <= HW'(w_b_h) * HW'(10000);
            r_b_j0 <= 7'(w_b_h >> (FRAC_BITS - 6));
        end
    end

    // Segment fixup: table knots are rounded, so the segment is off by at most one
    always_comb begin
        w_c_j0c = (r_b_j0 > 7'd63) ? 6'd63 : r_b_j0[5:0];
        w_c_jn  = 7'(w_c_j0c) + 7'd1;
        w_c_j   = w_c_j0c;
        if ((w_c_j0c < 6'd63) && (r_b_hh >= (HW'(KNOT_X[w_c_jn]) << FRAC_BITS))) begin
            w_c_j = w_c_j0c + 6'd1;
        end else if ((w_c_j0c > 6'd0) && (r_b_hh < (HW'(KNOT_X[w_c_j0c]) << FRAC_BITS))) begin
            w_c_j = w_c_j0c - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_hh <= r_b_hh;
            r_c_j  <= w_c_j;
        end
    end

    // Interpolation terms for the segment
    assign w_d_dh = DHW'(r_c_hh - (HW'(KNOT_X[r_c_j]) << FRAC_BITS));
    assign w_d_dt = 9'(KNOT_T[7'(r_c_j) + 7'd1] - KNOT_T[r_c_j]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_base <= BW'(KNOT_BASE[r_c_j]);
            r_d_prod <= PW'(w_d_dt) * PW'(w_d_dh);
            r_d_den  <= BW'(KNOT_DEN[r_c_j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_num <= (NW2'(r_d_base) << FRAC_BITS) + NW2'(r_d_prod);
            r_e_den <= r_d_den;
        end
    end

    // Perceptual hue in Q0.F
    cmg_div #(
        .N    (NW2),
        .D    (BW),
        .Q    (FRAC_BITS),
        .STEP (DIV_STEP)
    ) u_div_hue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_e_num),
        .i_den (r_e_den),
        .o_quo (w_hue)
    );

    // Hexcone with s = v = 1, and the square-root inputs for each map
    assign w_f_h6     = (FRAC_BITS+3)'(w_hue) * (FRAC_BITS+3)'(6);
    assign w_f_sector = (w_f_h6[FRAC_BITS+2:FRAC_BITS] > 3'd5) ? 3'd5
                                                               : w_f_h6[FRAC_BITS+2:FRAC_BITS];
    assign w_f_frac   = {1'b0, w_f_h6[FRAC_BITS-1:0]};
    assign w_f_t      = r_t_dly[T_DLY-1];
    assign w_f_ti     = ONE_Q - w_f_t;

    always_comb begin
        w_f_x[0] = w_f_t;
        w_f_x[1] = '0;
        w_f_x[2] = w_f_ti;
        case (r_map_mode)
            MODE_RED_BLUE: begin
                w_f_x[0] = w_f_t;
                w_f_x[1] = '0;
                w_f_x[2] = w_f_ti;
            end
            MODE_RAINBOW: begin
                case (w_f_sector)
                    3'd0: begin
                        w_f_x[0] = ONE_Q;
                        w_f_x[1] = w_f_frac;
                        w_f_x[2] = '0;
                    end
                    3'd1: begin
                        w_f_x[0] = ONE_Q - w_f_frac;
                        w_f_x[1] = ONE_Q;
                        w_f_x[2] = '0;
                    end
                    3'd2: begin
                        w_f_x[0] = '0;
                        w_f_x[1] = ONE_Q;
                        w_f_x[2] = w_f_frac;
                    end
                    3'd3: begin
                        w_f_x[0] = '0;
                        w_f_x[1] = ONE_Q - w_f_frac;
                        w_f_x[2] = ONE_Q;
                    end
                    3'd4: begin
                        w_f_x[0] = w_f_frac;
                        w_f_x[1] = '0;
                        w_f_x[2] = ONE_Q;
                    end
                    default: begin
                        w_f_x[0] = ONE_Q;
                        w_f_x[1] = '0;
                        w_f_x[2] = ONE_Q - w_f_frac;
                    end
                endcase
            end
            MODE_GRAY: begin
                w_f_x[0] = w_f_t;
                w_f_x[1] = w_f_t;
                w_f_x[2] = w_f_t;
            end
            default: begin
                w_f_x[0] = w_f_ti;
                w_f_x[1] = w_f_ti;
                w_f_x[2] = w_f_ti;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_f_x[c] <= w_f_x[c];
            end
        end
    end

    // Three square-root lanes
    for (genvar c = 0; c < 3; c++) begin : g_sqrt
        cmg_sqrt #(
            .W    (FRAC_BITS),
            .STEP (DIV_STEP)
        ) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_x    (r_f_x[c]),
            .o_root (w_sq[c])
        );
    end

    // Red-blue rescale so the larger component is exactly one
    assign w_max = (w_sq[0] > w_sq[2]) ? w_sq[0]
                 : ((w_sq[2] == '0) ? QW'(1) : w_sq[2]);

    cmg_div #(
        .N    (2 * FRAC_BITS + 1),
        .D    (QW),
        .Q    (QW),
        .STEP (DIV_STEP)
    ) u_div_red (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({w_sq[0], {FRAC_BITS{1'b0}}}),
        .i_den (w_max),
        .o_quo (w_dr)
    );

    cmg_div #(
        .N    (2 * FRAC_BITS + 1),
        .D    (QW),
        .Q    (QW),
        .STEP (DIV_STEP)
    ) u_div_blue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({w_sq[2], {FRAC_BITS{1'b0}}}),
        .i_den (w_max),
        .o_quo (w_db)
    );

    // Root results wait for the rescale dividers
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_sq_dly[0][c] <= w_sq[c];
            end
            for (int k = 1; k < L4; k++) begin
                for (int c = 0; c < 3; c++) begin
                    r_sq_dly[k][c] <= r_sq_dly[k-1][c];
                end
            end
        end
    end

    // Pick components and scale by 255.499 (times 1000)
    always_comb begin
        w_h_c[0] = (r_map_mode == MODE_RED_BLUE) ? w_dr : r_sq_dly[L4-1][0];
        w_h_c[1] = r_sq_dly[L4-1][1];
        w_h_c[2] = (r_map_mode == MODE_RED_BLUE) ? w_db : r_sq_dly[L4-1][2];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_h_prod[c] <= CW'(w_h_c[c]) * CW'(TO_BYTE_MUL);
            end
        end
    end

    // Drop the fraction, estimate the divide by 1000
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_i_y[c] = YW'(r_h_prod[c] >> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                r_i_y[c]   <= w_i_y[c];
                r_i_est[c] <= EW'(w_i_y[c]) * EW'(RECIP_MUL);
            end
        end
    end

    // Correct the estimate by one and saturate into the output register
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int c = 0; c < 3; c++) begin
                logic [8:0]    v_q0;
                logic [YW-1:0] v_rem;
                logic [8:0]    v_q;
                v_q0  = 9'(r_i_est[c] >> RECIP_SHIFT);
                v_rem = r_i_y[c] - YW'(v_q0) * YW'(BYTE_DIV);
                v_q   = v_q0 + 9'(v_rem >= YW'(BYTE_DIV));
                r_j_byte[c] <= (v_q > 9'd255) ? 8'hFF : v_q[7:0];
            end
        end
    end

    assign o_out.valid     = r_vld[LAT-1];
    assign o_out.red       = r_j_byte[0];
    assign o_out.green     = r_j_byte[1];
    assign o_out.blue      = r_j_byte[2];
    assign o_out.entry_out = r_idx[LAT-1];

endmodule

/* bench/tb_colormap_entry_generator.sv */
// Testbench for the colormap entry generator: predicted colors per index, all map modes.
`timescale 1ns / 1ps

module tb_colormap_entry_generator;
    import cmg_pkg::*;

    localparam int MAX_ENTRIES = 254;
    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = 44;
    localparam longint ONE_Q   = 64'd1 << FRAC_BITS;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] entry_out;
    } t_color;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cmg_in_if  in_ch ();
    cmg_out_if out_ch ();
    cmg_cfg_if cfg_ch ();

    colormap_entry_generator #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .FRAC_BITS(FRAC_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch.sink),
        .i_cfg(cfg_ch.sink),
        .o_out(out_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of the registers
    t_map_mode  cur_mode = MODE_RAINBOW;
    logic [7:0] cur_max  = 8'd253;

    t_color color_queue [$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     send_idle_on = 1'b1;
    bit     recv_idle_on = 1'b1;

    function automatic longint isqrt(longint v);
        longint res;
        longint b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint root_q(longint x);
        return isqrt(x << FRAC_BITS);
    endfunction

    function automatic logic [7:0] q_to_byte(longint x);
        longint v;
        v = (x * TO_BYTE_MUL) / (longint'(BYTE_DIV) << FRAC_BITS);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // Perceptual hue: piecewise-linear through the knot table
    function automatic longint perceptual_hue(longint h);
        int j;
        longint dx, dt, dh;
        j = 0;
        while (j < HUE_POINTS - 2 && longint'(KNOT_X[j + 1]) * ONE_Q <= h * 10000) j++;
        dx = KNOT_X[j + 1] - KNOT_X[j];
        dt = KNOT_T[j + 1] - KNOT_T[j];
        dh = h * 10000 - longint'(KNOT_X[j]) * ONE_Q;
        return (longint'(KNOT_T[j]) * ONE_Q * dx + dt * dh) / (10000 * dx);
    endfunction

    function automatic t_color predict_color(logic [7:0] index);
        t_color c;
        longint idx, t, r, g, b, m, h6, sector, f;
        idx = index;
        if (idx > cur_max) idx = cur_max;
        t = (cur_max == 0) ? 0 : (idx << FRAC_BITS) / cur_max;
        if (t > ONE_Q) t = ONE_Q;
        case (cur_mode)
            MODE_RED_BLUE: begin
                r = root_q(t);
                g = 0;
                b = root_q(ONE_Q - t);
                m = (r > b) ? r : b;
                if (m == 0) m = 1;
                r = (r << FRAC_BITS) / m;
                b = (b << FRAC_BITS) / m;
            end
            MODE_RAINBOW: begin
                h6 = perceptual_hue(ONE_Q - t) * 6;
                sector = h6 >> FRAC_BITS;
                f = h6 & (ONE_Q - 1);
                if (sector > 5) sector = 5;
                case (sector)
                    0: begin r = ONE_Q; g = f; b = 0; end
                    1: begin r = ONE_Q - f; g = ONE_Q; b = 0; end
                    2: begin r = 0; g = ONE_Q; b = f; end
                    3: begin r = 0; g = ONE_Q - f; b = ONE_Q; end
                    4: begin r = f; g = 0; b = ONE_Q; end
                    default: begin r = ONE_Q; g = 0; b = ONE_Q - f; end
                endcase
                r = root_q(r);
                g = root_q(g);
                b = root_q(b);
            end
            MODE_GRAY: begin
                r = root_q(t); g = r; b = r;
            end
            default: begin
                r = root_q(ONE_Q - t); g = r; b = r;
            end
        endcase
        c.red = q_to_byte(r);
        c.green = q_to_byte(g);
        c.blue = q_to_byte(b);
        c.entry_out = idx[7:0];
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("colormap_entry_generator regression: fail");
            $finish;
        end
    end

    // Sink side: random stall, compare each beat to the oldest prediction
    initial out_ch.ready = 1'b0;
    always @(negedge i_clk) begin
        out_ch.ready <= !(recv_idle_on && $urandom_range(99) < 23);
    end

    always @(posedge i_clk) begin
        t_color got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.red, out_ch.green, out_ch.blue, out_ch.entry_out};
            if (color_queue.size() == 0) begin
                report_mismatch("unexpected beat, entry", got.entry_out, -1);
            end else begin
                want = color_queue.pop_front();
                if (got.red !== want.red) report_mismatch("red", got.red, want.red);
                if (got.green !== want.green)
                    report_mismatch("green", got.green, want.green);
                if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
                if (got.entry_out !== want.entry_out)
                    report_mismatch("entry_out", got.entry_out, want.entry_out);
            end
        end
    end

    // One index beat, with a random idle gap ahead of it; valid stays high
    // after the accept so beats can follow back to back
    task automatic send_index(logic [7:0] index);
        while (send_idle_on && $urandom_range(99) < 23) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.entry_index <= index;
        color_queue.push_back(predict_color(index));
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (color_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic write_register(logic index, logic [7:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (index == REG_MAP_MODE) begin
            cur_mode = t_map_mode'(data[1:0]);
        end else begin
            cur_max = (data > MAX_ENTRIES - 1) ? 8'(MAX_ENTRIES - 1) : data;
        end
    endtask

    task automatic set_map(t_map_mode mode, logic [7:0] max_value);
        drain_pipeline();
        write_register(REG_MAP_MODE, 8'(mode));
        write_register(REG_MAX_INDEX, max_value);
    endtask

    // Reset defaults, extreme indexes, saturation
    task automatic test_reset_defaults();
        send_index(8'd0);
        send_index(8'd253);
        send_index(8'd255);
        send_index(8'd127);
        send_index(8'd170);
    endtask

    // Every mode at the ends and middle of the ratio, then odd max_index values
    task automatic test_directed_modes();
        for (int m = 0; m < 4; m++) begin
            set_map(t_map_mode'(m), 8'd253);
            send_index(8'd0);
            send_index(8'd126);
            send_index(8'd253);
            send_index(8'd254);
        end
        set_map(MODE_RAINBOW, 8'd0);     // zero divisor gives t = 0
        send_index(8'd0);
        send_index(8'd200);
        set_map(MODE_RED_BLUE, 8'd255);  // stored as the largest legal index
        send_index(8'd255);
        send_index(8'd1);
        set_map(MODE_GRAY, 8'd1);
        send_index(8'd1);
    endtask

    // Random indexes under random modes and fixed or random max_index, with a no-idle stretch and a full drain
    task automatic test_random_entries();
        logic [7:0] max_value;
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: max_value = 8'd253;
                1: max_value = 8'd255;
                2: max_value = 8'd0;
                3: max_value = 8'd2;
                default: max_value = 8'($urandom_range(255));
            endcase
            set_map(t_map_mode'($urandom_range(3)), max_value);
            send_idle_on = (phase != 5);
            recv_idle_on = (phase != 5);
            for (int k = 0; k < 50; k++) begin
                if (k == 25) begin
                    in_ch.valid <= 1'b0;
                    while (color_queue.size() != 0) @(negedge i_clk);
                end
                send_index(($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(max_value)));
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.entry_index = 8'd0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_MAP_MODE;
        cfg_ch.data = 8'd0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_directed_modes();
        test_random_entries();
        in_ch.valid <= 1'b0;
        while (color_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
        if (error_count == 0) begin
            $display("colormap_entry_generator regression: pass");
        end else begin
            $display("colormap_entry_generator regression: fail");
        end
        $finish;
    end
endmodule
